/* src/c_comment_blanker_defines.svh */
// Assertion macros used by the comment blanker queue.
`ifndef C_COMMENT_BLANKER_DEFINES_SVH
`define C_COMMENT_BLANKER_DEFINES_SVH

`ifndef SYNTH
// Check a property every clock edge outside reset.
`define CCB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("ccb assertion failed");
// Check that cond in one cycle implies cons in the next.
`define CCB_ASSERT_NEXT(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("ccb assertion failed");
`else
`define CCB_ASSERT(lbl, prop)
`define CCB_ASSERT_NEXT(lbl, cond, cons)
`endif

`endif

/* src/ccb_pkg.sv */
// Types, constants and the classify function of the comment blanker.
package ccb_pkg;

	localparam int CODE_W = 21;

	localparam logic [CODE_W-1:0] CH_BSLASH = CODE_W'('h5C);
	localparam logic [CODE_W-1:0] CH_NL     = CODE_W'('h0A);
	localparam logic [CODE_W-1:0] CH_STAR   = CODE_W'('h2A);
	localparam logic [CODE_W-1:0] CH_SLASH  = CODE_W'('h2F);
	localparam logic [CODE_W-1:0] CH_SPACE  = CODE_W'('h20);

	// Queue depth, a power of two
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		M_NORMAL      = 3'd0,
		M_LINE        = 3'd1,
		M_LINE_CONT   = 3'd2,
		M_BLOCK       = 3'd3,
		M_BEGIN_LINE  = 3'd4,
		M_BEGIN_BLOCK = 3'd5,
		M_END_BLOCK   = 3'd6
	} mode_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		mode_t             mode;
	} judge_t;

	// One queue entry: up to two output characters; the second one ends the text
	typedef struct packed {
		logic              first_valid;
		logic [CODE_W-1:0] first_code;
		logic              has_last;
		logic [CODE_W-1:0] last_code;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

	function automatic judge_t judge(mode_t mode, logic [CODE_W-1:0] ch,
			logic [CODE_W-1:0] nx, logic has_nx);
		judge_t r;
		r.code = ch;
		r.mode = mode;
		unique case (mode)
			M_LINE: begin
				if (ch == CH_BSLASH) begin
					if (has_nx) begin
						r.code = CH_SPACE;
						if (nx == CH_NL) r.mode = M_LINE_CONT;
					end
				end else if (ch == CH_NL) begin
					r.mode = M_NORMAL;
				end else begin
					r.code = CH_SPACE;
				end
			end
			M_LINE_CONT: begin
				r.mode = M_LINE;
			end
			M_BLOCK: begin
				if (ch == CH_STAR) begin
					r.code = CH_SPACE;
					if (has_nx && nx == CH_SLASH) r.mode = M_END_BLOCK;
				end else if (ch != CH_NL) begin
					r.code = CH_SPACE;
				end
			end
			M_BEGIN_LINE: begin
				r.mode = M_LINE;
				r.code = CH_SPACE;
			end
			M_BEGIN_BLOCK: begin
				r.mode = M_BLOCK;
				r.code = CH_SPACE;
			end
			M_END_BLOCK: begin
				r.mode = M_NORMAL;
				r.code = CH_SPACE;
			end
			default: begin
				// normal text, and the unused encoding
				r.mode = M_NORMAL;
				if (has_nx && ch == CH_SLASH) begin
					if (nx == CH_SLASH) begin
						r.mode = M_BEGIN_LINE;
						r.code = CH_SPACE;
					end else if (nx == CH_STAR) begin
						r.mode = M_BEGIN_BLOCK;
						r.code = CH_SPACE;
					end
				end
			end
		endcase
		return r;
	endfunction

endpackage

/* src/ccb_in_if.sv */
// Input character channel: valid/ready with code point and end-of-text mark.
interface ccb_in_if;
	logic                      valid;
	logic                      ready;
	logic [ccb_pkg::CODE_W-1:0] char_code;
	logic                      end_of_text;

	modport source (output valid, output char_code, output end_of_text, input ready);
	modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

/* src/ccb_out_if.sv */
// Output character channel: valid/ready with blanked code point and final mark.
interface ccb_out_if;
	logic                      valid;
	logic                      ready;
	logic [ccb_pkg::CODE_W-1:0] out_code;
	logic                      final_flag;

	modport source (output valid, output out_code, output final_flag, input ready);
	modport sink (input valid, input out_code, input final_flag, output ready);
endinterface

/* src/ccb_front.sv */
// Front end: accepts characters, tracks comment mode and classifies them.
module ccb_front (
	input  logic             clk,
	input  logic             arst_n,
	ccb_in_if.sink           chars,
	input  logic             full,
	output ccb_pkg::push_t   push
);

	ccb_pkg::mode_t              mode_q;
	logic [ccb_pkg::CODE_W-1:0]  held_q;
	logic                        held_valid_q;
	logic                        accept;
	ccb_pkg::judge_t             j_held;
	ccb_pkg::judge_t             j_last;
	ccb_pkg::mode_t              mode_mid;

	assign chars.ready = !full;
	assign accept      = chars.valid && chars.ready;

	always_comb begin
		j_held   = ccb_pkg::judge(mode_q, held_q, chars.char_code, 1'b1);
		mode_mid = held_valid_q ? j_held.mode : mode_q;
		j_last   = ccb_pkg::judge(mode_mid, chars.char_code, '0, 1'b0);

		push.valid             = accept && (held_valid_q || chars.end_of_text);
		push.entry.first_valid = held_valid_q;
		push.entry.first_code  = j_held.code;
		push.entry.has_last    = chars.end_of_text;
		push.entry.last_code   = j_last.code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= ccb_pkg::M_NORMAL;
			held_valid_q <= 1'b0;
			held_q       <= '0;
		end else if (accept) begin
			if (chars.end_of_text) begin
				// flush: back to normal text, nothing held
				mode_q       <= ccb_pkg::M_NORMAL;
				held_valid_q <= 1'b0;
				held_q       <= '0;
			end else begin
				mode_q       <= mode_mid;
				held_valid_q <= 1'b1;
				held_q       <= chars.char_code;
			end
		end
	end

endmodule

/* src/ccb_queue.sv */
// Small FIFO of classified entries between front and back end.
`include "c_comment_blanker_defines.svh"

module ccb_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  ccb_pkg::push_t  push,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output ccb_pkg::entry_t head
);

	ccb_pkg::entry_t                 mem [ccb_pkg::QDEPTH];
	logic [ccb_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [ccb_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [ccb_pkg::QCNT_W-1:0]      count_q;

	assign full  = count_q == ccb_pkg::QCNT_W'(ccb_pkg::QDEPTH);
	assign empty = count_q == '0;
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) mem[wr_ptr_q] <= push.entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)        rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push.valid, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`CCB_ASSERT(a_no_push_full, !(push.valid && full))
	`CCB_ASSERT(a_no_pop_empty, !(pop && empty))
	`CCB_ASSERT(a_count_range, count_q <= ccb_pkg::QCNT_W'(ccb_pkg::QDEPTH))
	`CCB_ASSERT_NEXT(a_push_lands, push.valid && !pop, !empty)

endmodule

/* src/ccb_back.sv */
// Back end: sends each queued entry out as one or two characters.
module ccb_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  ccb_pkg::entry_t head,
	output logic            pop,
	ccb_out_if.source       blanked
);

	logic second_q;
	logic show_first;
	logic accept;

	assign show_first         = head.first_valid && !second_q;
	assign blanked.valid      = !empty;
	assign blanked.out_code   = show_first ? head.first_code : head.last_code;
	assign blanked.final_flag = !show_first;
	assign accept             = blanked.valid && blanked.ready;
	assign pop                = accept && (!show_first || !head.has_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= 1'b0;
		end else if (accept) begin
			second_q <= !pop;
		end
	end

endmodule

/* src/c_comment_blanker.sv */
// Top level of the C comment blanker: front end, queue and back end.
//
// Channel   Modport  Payload                      Transaction
// chars     sink     char_code[20:0], end_of_text valid && ready
// blanked   source   out_code[20:0], final_flag   valid && ready
//
// One character per cycle sustained while blanked.ready stays high: the
// front end classifies a transaction in the cycle it is accepted; the back
// end sends one character per cycle. A transaction marked end_of_text yields
// up to two characters, sent in turn; the four-entry queue absorbs that.
// First output appears the cycle after the second character is accepted
// (one character of lookahead is held), or after an end_of_text transaction.
// Reset (arst_n low) clears mode, held character and queue at once.
// Output stalls fill the queue; chars.ready drops only when it is full.
module c_comment_blanker (
	input  logic      clk,
	input  logic      arst_n,
	ccb_in_if.sink    chars,
	ccb_out_if.source blanked
);

	ccb_pkg::push_t  push;
	ccb_pkg::entry_t head;
	logic            full;
	logic            empty;
	logic            pop;

	// Hold one pending character and judge it against the next one
	ccb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.full   (full),
		.push   (push)
	);

	// Decouple classification from output stalls
	ccb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (full),
		.empty  (empty),
		.head   (head)
	);

	// Advance through each entry, one character per transaction
	ccb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (empty),
		.head    (head),
		.pop     (pop),
		.blanked (blanked)
	);

endmodule
